@@ rtl/tile_ring_mosaic_store_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the tile ring mosaic store checker
// ----------------------------------------------------------------------------
`ifndef TILE_RING_MOSAIC_STORE_ASSERT_SVH
`define TILE_RING_MOSAIC_STORE_ASSERT_SVH

// Clocked assertion with an asynchronous active-low reset gate
`define TRMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked only while the response channel holds a transfer
`define TRMS_ASSERT_RSP(lbl, clk, rst_n, vld, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) vld |-> prop) else $error(msg);

`endif

@@ rtl/trms_pkg.sv @@
// ----------------------------------------------------------------------------
// trms_pkg
// Types, geometry constants and coordinate helpers of the tile ring mosaic
// store.
// ----------------------------------------------------------------------------
package trms_pkg;

	// Geometry
	localparam int TILE_SIDE   = 24;
	localparam int GRID_SIDE   = 4;
	localparam int RING_SLOTS  = GRID_SIDE * GRID_SIDE;
	localparam int TILE_AREA   = TILE_SIDE * TILE_SIDE;
	localparam int MOSAIC_SIDE = TILE_SIDE * GRID_SIDE;
	localparam int STORE_DEPTH = RING_SLOTS * TILE_AREA;

	// Widths
	localparam int COLOR_W = 8;
	localparam int COORD_W = 7;
	localparam int CNT_W   = 5;
	localparam int PIX_W   = 3 * COLOR_W;
	localparam int SLOT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int GRID_W  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int TILE_W  = (TILE_SIDE > 1) ? $clog2(TILE_SIDE) : 1;
	localparam int POS_W   = (TILE_AREA > 1) ? $clog2(TILE_AREA) : 1;
	localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STAT_STORED    = 2'd0,
		STAT_TILE_DONE = 2'd1,
		STAT_READ_OK   = 2'd2,
		STAT_NOT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_DONE
	} fsm_t;

	typedef struct packed {
		func_t              func;
		logic [COLOR_W-1:0] red_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] blue_in;
		logic [COORD_W-1:0] mosaic_x;
		logic [COORD_W-1:0] mosaic_y;
	} tile_in_t;

	typedef struct packed {
		status_t            status;
		logic [COLOR_W-1:0] red_out;
		logic [COLOR_W-1:0] green_out;
		logic [COLOR_W-1:0] blue_out;
		logic [CNT_W-1:0]   tiles_held;
	} tile_out_t;

	// Tile column or row and the offset inside that tile
	typedef struct packed {
		logic [GRID_W-1:0] tile_idx;
		logic [TILE_W-1:0] offs;
	} tile_pos_t;

	// Clamp a mosaic coordinate and split it into tile index and offset
	function automatic tile_pos_t split_coord(input logic [COORD_W-1:0] c);
		tile_pos_t          p;
		logic [COORD_W-1:0] cl;
		cl = (c >= COORD_W'(MOSAIC_SIDE)) ? COORD_W'(MOSAIC_SIDE - 1) : c;
		p.tile_idx = '0;
		p.offs = TILE_W'(cl);
		for (int g = 1; g < GRID_SIDE; g++) begin
			if (cl >= COORD_W'(g * TILE_SIDE)) begin
				p.tile_idx = GRID_W'(g);
				p.offs = TILE_W'(cl - COORD_W'(g * TILE_SIDE));
			end
		end
		return p;
	endfunction

endpackage

@@ rtl/tile_ring_mosaic_store.sv @@
// ----------------------------------------------------------------------------
// tile_ring_mosaic_store
// Ring of square RGB tiles kept in one pixel store and read back as a mosaic.
// ----------------------------------------------------------------------------
// A pixel write and a read refused because the ring is not yet full each have
// their result registered at the edge the request transfers. A read of a full
// ring passes the coordinate register, the read of the single pixel store and
// the result register in turn, and the result waits to be loaded while the
// response register cannot accept it; the request side stalls until that
// result is loaded. A new request is taken while an earlier result still
// waits on the response side, as long as the response register can accept
// the result it produces. The pixel store needs no clearing after reset.
module tile_ring_mosaic_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  trms_pkg::tile_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output trms_pkg::tile_out_t rsp
);
	import trms_pkg::*;

	// Pixel store
	logic [PIX_W-1:0] store [STORE_DEPTH];
	logic [PIX_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [PIX_W-1:0] wr_data;
	logic              mem_we;
	logic              mem_re;

	// Ring state
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  count_q;
	logic              wr_upd;
	logic              tile_last;
	logic [SLOT_W-1:0] slot_next;
	logic [CNT_W-1:0]  count_next;
	logic              ring_full;

	// Read operand stage
	logic [SLOT_W-1:0] slot_s1;
	logic [TILE_W-1:0] rx_s1;
	logic [TILE_W-1:0] ry_s1;
	logic              load_s1;
	tile_pos_t         px;
	tile_pos_t         py;
	logic [SLOT_W:0]   grid_pos;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] rd_slot;

	// Control and response
	fsm_t       state_q;
	fsm_t       state_d;
	logic       out_free;
	logic       req_fire;
	logic       rsp_load;
	tile_out_t  rsp_d;
	tile_out_t  rsp_q;
	logic       rsp_valid_q;

	// Handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign req_fire  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Write pointer arithmetic
	assign ring_full  = (count_q == CNT_W'(RING_SLOTS));
	assign tile_last  = (pos_q == POS_W'(TILE_AREA - 1));
	assign slot_next  = (slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 : slot_q + 1'b1;
	assign count_next = ring_full ? count_q : count_q + 1'b1;
	assign wr_addr    = ADDR_W'(slot_q) * ADDR_W'(TILE_AREA) + ADDR_W'(pos_q);
	assign wr_data    = {req.red_in, req.green_in, req.blue_in};

	// Map a mosaic pixel to its slot, oldest tile at top left
	assign px       = split_coord(req.mosaic_x);
	assign py       = split_coord(req.mosaic_y);
	assign grid_pos = (SLOT_W + 1)'(py.tile_idx) * (SLOT_W + 1)'(GRID_SIDE)
	                + (SLOT_W + 1)'(px.tile_idx);
	assign slot_sum = (SLOT_W + 1)'(slot_q) + grid_pos;
	assign rd_slot  = (slot_sum >= (SLOT_W + 1)'(RING_SLOTS))
	                ? SLOT_W'(slot_sum - (SLOT_W + 1)'(RING_SLOTS))
	                : SLOT_W'(slot_sum);
	assign rd_addr  = ADDR_W'(slot_s1) * ADDR_W'(TILE_AREA)
	                + ADDR_W'(ry_s1) * ADDR_W'(TILE_SIDE) + ADDR_W'(rx_s1);

	// Next state and outputs
	always_comb begin
		state_d  = state_q;
		rsp_load = 1'b0;
		rsp_d    = '0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		load_s1  = 1'b0;
		wr_upd   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.func == FUNC_WRITE) begin
						mem_we   = 1'b1;
						wr_upd   = 1'b1;
						rsp_load = 1'b1;
						rsp_d.status     = tile_last ? STAT_TILE_DONE : STAT_STORED;
						rsp_d.tiles_held = tile_last ? count_next : count_q;
					end else if (!ring_full) begin
						rsp_load = 1'b1;
						rsp_d.status     = STAT_NOT_FULL;
						rsp_d.tiles_held = count_q;
					end else begin
						load_s1 = 1'b1;
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				mem_re  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					rsp_load = 1'b1;
					rsp_d.status     = STAT_READ_OK;
					rsp_d.red_out    = rd_data_q[3*COLOR_W-1:2*COLOR_W];
					rsp_d.green_out  = rd_data_q[2*COLOR_W-1:COLOR_W];
					rsp_d.blue_out   = rd_data_q[COLOR_W-1:0];
					rsp_d.tiles_held = count_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance write pointer, pixel position and tile count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			pos_q   <= '0;
			count_q <= '0;
		end else if (wr_upd) begin
			if (tile_last) begin
				pos_q   <= '0;
				slot_q  <= slot_next;
				count_q <= count_next;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Hold read operands
	always_ff @(posedge clk) begin
		if (load_s1) begin
			slot_s1 <= rd_slot;
			rx_s1   <= px.offs;
			ry_s1   <= py.offs;
		end
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_data_q <= store[rd_addr];
		end
	end

	// Response register: load a result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

@@ rtl/trms_checker.sv @@
// ----------------------------------------------------------------------------
// trms_checker
// Port-level checks of the tile ring mosaic store response channel.
// ----------------------------------------------------------------------------
`include "tile_ring_mosaic_store_assert.svh"

module trms_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input trms_pkg::tile_out_t rsp
);
	import trms_pkg::*;

	// A stalled response holds until it transfers
	`TRMS_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "response changed while stalled")

	// Tile count never passes the ring size
	`TRMS_ASSERT_RSP(a_count_max, clk, arst_n, rsp_valid, rsp.tiles_held <= CNT_W'(RING_SLOTS), "tile count above ring size")

	// Colors stay zero unless a read succeeded
	`TRMS_ASSERT_RSP(a_rgb_zero, clk, arst_n, rsp_valid && rsp.status != STAT_READ_OK, (rsp.red_out == '0) && (rsp.green_out == '0) && (rsp.blue_out == '0), "color on a non-read result")

	// A read succeeds exactly when the ring is full
	`TRMS_ASSERT_RSP(a_read_full, clk, arst_n, rsp_valid && (rsp.status == STAT_READ_OK || rsp.status == STAT_NOT_FULL), (rsp.status == STAT_READ_OK) == (rsp.tiles_held == CNT_W'(RING_SLOTS)), "read status disagrees with tile count")

endmodule

bind tile_ring_mosaic_store trms_checker u_trms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
